/* hdl/mcfc_pkg.sv */
`timescale 1ns / 1ps
// mcfc_pkg: shared constants and types of the multichannel filter chain
// register indexes, datapath widths, rounding constants, stage enable layout
// no dependencies
package mcfc_pkg;

  // configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_STAGE_ENABLES   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LOWPASS_ALPHA   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HIGHPASS_ALPHA  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_NOTCH_GAIN      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_NOTCH_COS_TERM  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_NOTCH_FEEDBACK2 = 3'd5;

  localparam logic [14:0] NOTCH_GAIN_RESET = 15'd16384;

  // channel tag width
  localparam int CHANNEL_W = 4;

  // datapath widths: stored values, multiplier operands, product, notch sum
  localparam int STATE_W = 32;
  localparam int COEF_W  = 17;
  localparam int OPND_W  = 33;
  localparam int PROD_W  = COEF_W + OPND_W;
  localparam int ACC_W   = PROD_W + 3;
  localparam int WIDE_W  = 40;

  // dc removal factor, 0.01 in Q0.16
  localparam logic signed [COEF_W-1:0] DC_SMOOTH_Q16 = 17'sd655;

  // half an lsb before the round-half-up shifts
  localparam logic signed [PROD_W-1:0] ROUND_Q16 = 50'sd32768;
  localparam logic signed [ACC_W-1:0]  ROUND_Q14 = 53'sd8192;

  // stage enable bits, bit0 low-pass up to bit4 rectify
  typedef struct packed {
    logic rectify;
    logic dc;
    logic notch;
    logic highpass;
    logic lowpass;
  } stage_en_t;

endpackage

/* hdl/multichannel_filter_chain_unit.sv */
`timescale 1ns / 1ps
// multichannel_filter_chain_unit: per-channel low-pass, high-pass, notch,
// dc removal and rectify chain, channel state held in one memory
// depends on mcfc_pkg
//
//  port group   direction  handshake            payload
//  input        in         in_valid/in_ready    channel, sample
//  output       out        out_valid/out_ready  out_channel, filtered
//  config       in         cfg_write            cfg_index, cfg_data
//
// An item takes the accept cycle (state memory read) and 11 steps that
// share one 17x33 multiplier for 8 products, with the update, notch sum
// and output steps among them.
// Reset clears control and per-channel valid bits and sets configuration
// defaults; an unwritten channel reads as zero state, so no clearing pass.
// in_ready is high whenever no item is in flight, also while a result word
// waits; the last step holds until the output register is free.
module multichannel_filter_chain_unit #(
  parameter int CHANNELS    = 16,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [mcfc_pkg::CHANNEL_W-1:0]         channel,
  input  logic signed [SAMPLE_BITS-1:0]          sample,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [mcfc_pkg::CHANNEL_W-1:0]         out_channel,
  output logic signed [SAMPLE_BITS-1:0]          filtered,
  input  logic                                   cfg_write,
  input  logic [mcfc_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [mcfc_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SW = mcfc_pkg::STATE_W;
  localparam int CW = mcfc_pkg::COEF_W;
  localparam int OW = mcfc_pkg::OPND_W;
  localparam int PW = mcfc_pkg::PROD_W;
  localparam int AC = mcfc_pkg::ACC_W;
  localparam int WW = mcfc_pkg::WIDE_W;

  localparam logic signed [OW-1:0] SAT_HI = OW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [OW-1:0] SAT_LO = OW'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

  localparam logic signed [WW-1:0] S32_HI = 40'sd2147483647;
  localparam logic signed [WW-1:0] S32_LO = -40'sd2147483648;

  // controller states
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_CALC = 1'b1;

  // sequencer steps
  localparam logic [3:0] STEP_LP_MUL    = 4'd0;
  localparam logic [3:0] STEP_HP_MUL    = 4'd1;
  localparam logic [3:0] STEP_TAP_X1    = 4'd2;
  localparam logic [3:0] STEP_TAP_X2    = 4'd3;
  localparam logic [3:0] STEP_TAP_Y1    = 4'd4;
  localparam logic [3:0] STEP_TAP_Y2    = 4'd5;
  localparam logic [3:0] STEP_TAP_X0    = 4'd6;
  localparam logic [3:0] STEP_NOTCH_SUM = 4'd7;
  localparam logic [3:0] STEP_DC_MUL    = 4'd8;
  localparam logic [3:0] STEP_DC_UPD    = 4'd9;
  localparam logic [3:0] STEP_OUT       = 4'd10;

  // one channel's filter state
  typedef struct packed {
    logic signed [SW-1:0]          lp;
    logic signed [SW-1:0]          hp;
    logic signed [SAMPLE_BITS-1:0] x1;
    logic signed [SAMPLE_BITS-1:0] x2;
    logic signed [SW-1:0]          y1;
    logic signed [SW-1:0]          y2;
    logic signed [SW-1:0]          dc;
  } entry_t;

  function automatic logic signed [SW-1:0] sat32(input logic signed [WW-1:0] v);
    logic signed [SW-1:0] r;
    if (v > S32_HI) begin
      r = S32_HI[SW-1:0];
    end else if (v < S32_LO) begin
      r = S32_LO[SW-1:0];
    end else begin
      r = v[SW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(input logic signed [OW-1:0] v);
    logic signed [SAMPLE_BITS-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[SAMPLE_BITS-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      r = v[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

  // round half up, then drop 16 fraction bits
  function automatic logic signed [WW-1:0] rnd16(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] t;
    t = (p + mcfc_pkg::ROUND_Q16) >>> 16;
    return WW'(t);
  endfunction

  // round half up, then drop 14 fraction bits
  function automatic logic signed [WW-1:0] rnd14(input logic signed [AC-1:0] a);
    logic signed [AC-1:0] t;
    t = (a + mcfc_pkg::ROUND_Q14) >>> 14;
    return WW'(t);
  endfunction

  // configuration registers
  mcfc_pkg::stage_en_t  stage_en;
  logic [15:0]          lowpass_alpha;
  logic [15:0]          highpass_alpha;
  logic [14:0]          notch_gain;
  logic signed [15:0]   notch_cos_term;
  logic signed [15:0]   notch_feedback2;

  // control
  logic       state;
  logic [3:0] step;
  logic       accept;
  logic       fire;

  // item payload and working registers
  logic [mcfc_pkg::CHANNEL_W-1:0] chan_q;
  logic [AW-1:0]                  addr_q;
  logic signed [SAMPLE_BITS-1:0]  sample_q;
  logic signed [PW-1:0]           prod_q;
  logic signed [AC-1:0]           acc_q;
  logic signed [SW-1:0]           v_q;
  logic signed [SW-1:0]           lp_n;
  logic signed [SW-1:0]           hp_n;
  logic signed [SW-1:0]           dc_n;
  logic signed [SW-1:0]           y_q;
  logic signed [SAMPLE_BITS-1:0]  x0_q;

  // state memory and valid bits
  entry_t        mem [CHANNELS];
  entry_t        rd_entry;
  logic          rd_vld;
  logic [CHANNELS-1:0] entry_vld;
  entry_t        cur;
  entry_t        wr_entry;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] chan_map [2**mcfc_pkg::CHANNEL_W];

  // datapath helpers
  logic signed [CW-1:0]          mul_coef;
  logic signed [OW-1:0]          mul_opnd;
  logic signed [SW-1:0]          smooth_base;
  logic signed [SW-1:0]          smooth_out;
  logic signed [SW-1:0]          notch_y;
  logic signed [SAMPLE_BITS-1:0] x0;
  logic signed [OW-1:0]          rect;
  logic signed [SAMPLE_BITS-1:0] result;

  // channel tag to memory row, tags past the channel count wrap
  for (genvar i = 0; i < 2**mcfc_pkg::CHANNEL_W; i++) begin : g_chan_map
    assign chan_map[i] = AW'(i % CHANNELS);
  end

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign fire     = (state == ST_CALC) && (step == STEP_OUT) && (!out_valid || out_ready);
  assign rd_addr  = chan_map[channel];

  // unwritten rows read as zero state
  assign cur = rd_vld ? rd_entry : '0;

  // multiplier operand select
  always_comb begin
    mul_coef = '0;
    mul_opnd = '0;
    case (step)
      STEP_LP_MUL: begin
        mul_coef = $signed({1'b0, lowpass_alpha});
        mul_opnd = OW'(sample_q) - OW'(cur.lp);
      end
      STEP_HP_MUL: begin
        mul_coef = $signed({1'b0, highpass_alpha});
        mul_opnd = OW'(sample_q) - OW'(cur.hp);
      end
      STEP_TAP_X1: begin
        mul_coef = CW'(notch_cos_term);
        mul_opnd = OW'(cur.x1);
      end
      STEP_TAP_X2: begin
        mul_coef = $signed({2'b00, notch_gain});
        mul_opnd = OW'(cur.x2);
      end
      STEP_TAP_Y1: begin
        mul_coef = -CW'(notch_cos_term);
        mul_opnd = OW'(cur.y1);
      end
      STEP_TAP_Y2: begin
        mul_coef = -CW'(notch_feedback2);
        mul_opnd = OW'(cur.y2);
      end
      STEP_TAP_X0: begin
        mul_coef = $signed({2'b00, notch_gain});
        mul_opnd = OW'(x0);
      end
      STEP_DC_MUL: begin
        mul_coef = mcfc_pkg::DC_SMOOTH_Q16;
        mul_opnd = OW'(v_q) - OW'(cur.dc);
      end
      default: begin
        mul_coef = '0;
        mul_opnd = '0;
      end
    endcase
  end

  // one-pole update shared by low-pass, high-pass estimate and dc estimate
  always_comb begin
    case (step)
      STEP_HP_MUL: smooth_base = cur.lp;
      STEP_TAP_X1: smooth_base = cur.hp;
      default:     smooth_base = cur.dc;
    endcase
    smooth_out = sat32(WW'(smooth_base) + rnd16(prod_q));
  end

  // notch input, notch output and final rectify and clamp
  always_comb begin
    x0      = sat_sample(OW'(v_q));
    notch_y = sat32(rnd14(acc_q + AC'(prod_q)));
    if (stage_en.rectify && v_q < 0) begin
      rect = -OW'(v_q);
    end else begin
      rect = OW'(v_q);
    end
    result = sat_sample(rect);
  end

  // write-back row, a stage that is off keeps its state
  always_comb begin
    wr_entry.lp = stage_en.lowpass  ? lp_n : cur.lp;
    wr_entry.hp = stage_en.highpass ? hp_n : cur.hp;
    wr_entry.x1 = stage_en.notch    ? x0_q : cur.x1;
    wr_entry.x2 = stage_en.notch    ? cur.x1 : cur.x2;
    wr_entry.y1 = stage_en.notch    ? y_q  : cur.y1;
    wr_entry.y2 = stage_en.notch    ? cur.y1 : cur.y2;
    wr_entry.dc = stage_en.dc       ? dc_n : cur.dc;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_en        <= '0;
      lowpass_alpha   <= '0;
      highpass_alpha  <= '0;
      notch_gain      <= mcfc_pkg::NOTCH_GAIN_RESET;
      notch_cos_term  <= '0;
      notch_feedback2 <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        mcfc_pkg::REG_STAGE_ENABLES:   stage_en        <= cfg_data[4:0];
        mcfc_pkg::REG_LOWPASS_ALPHA:   lowpass_alpha   <= cfg_data;
        mcfc_pkg::REG_HIGHPASS_ALPHA:  highpass_alpha  <= cfg_data;
        mcfc_pkg::REG_NOTCH_GAIN:      notch_gain      <= cfg_data[14:0];
        mcfc_pkg::REG_NOTCH_COS_TERM:  notch_cos_term  <= $signed(cfg_data);
        mcfc_pkg::REG_NOTCH_FEEDBACK2: notch_feedback2 <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // sequencer and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= STEP_LP_MUL;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_CALC;
            step  <= STEP_LP_MUL;
          end
        end
        ST_CALC: begin
          if (step != STEP_OUT) begin
            step <= step + 4'd1;
          end else if (fire) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // row valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_vld <= '0;
    end else if (fire) begin
      entry_vld[addr_q] <= 1'b1;
    end
  end

  // state memory, read on accept, written back on the output step
  always_ff @(posedge clk) begin
    if (fire) begin
      mem[addr_q] <= wr_entry;
    end
    if (accept) begin
      rd_entry <= mem[rd_addr];
      rd_vld   <= entry_vld[rd_addr];
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod_q <= mul_coef * mul_opnd;
    if (accept) begin
      chan_q   <= channel;
      addr_q   <= rd_addr;
      sample_q <= sample;
    end
    if (state == ST_CALC) begin
      case (step)
        STEP_HP_MUL: begin
          lp_n <= smooth_out;
          v_q  <= stage_en.lowpass ? smooth_out : SW'(sample_q);
        end
        STEP_TAP_X1: begin
          hp_n <= smooth_out;
          if (stage_en.highpass) begin
            v_q <= sat32(WW'(sample_q) - WW'(smooth_out));
          end
        end
        STEP_TAP_X2: acc_q <= AC'(prod_q);
        STEP_TAP_Y1: acc_q <= acc_q + AC'(prod_q);
        STEP_TAP_Y2: acc_q <= acc_q + AC'(prod_q);
        STEP_TAP_X0: begin
          acc_q <= acc_q + AC'(prod_q);
          x0_q  <= x0;
        end
        STEP_NOTCH_SUM: begin
          y_q <= notch_y;
          if (stage_en.notch) begin
            v_q <= notch_y;
          end
        end
        STEP_DC_UPD: begin
          dc_n <= smooth_out;
          if (stage_en.dc) begin
            v_q <= sat32(WW'(v_q) - WW'(smooth_out));
          end
        end
        STEP_OUT: begin
          if (fire) begin
            out_channel <= chan_q;
            filtered    <= result;
          end
        end
        default: ;
      endcase
    end
  end

  // checks
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_CALC |-> step <= STEP_OUT)
    else $error("sequencer step out of range");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_CALC && step == STEP_LP_MUL)
    else $error("accepted word did not start the sequence");

  a_out_from_fire: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_CALC && step == STEP_OUT))
    else $error("result word appeared without a finished item");

  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    fire |-> int'(addr_q) < CHANNELS)
    else $error("write-back row beyond channel count");

endmodule
